@@ sv/slae_pkg.sv @@
// Package: sizes, operation and status codes, and controller/datapath link types.
`default_nettype none
package slae_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = 5;
  localparam int FILL_W   = 5;
  localparam int VAL_W    = 16;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_DELETE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    RES_EMPTY = 1'b0,
    RES_HELD  = 1'b1
  } res_state_t;

  // controller to datapath
  typedef struct packed {
    logic    take;
    logic    rd;
    logic    upd;
    logic    ins;
    logic    del;
    status_t status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_lt_cnt;
    logic pos_le_cnt;
    logic full;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ sv/slae_if.sv @@
// Channel interfaces: operation request and result.
`default_nettype none
interface slae_op_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [slae_pkg::POS_W-1:0]     position;
  logic signed [slae_pkg::VAL_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface slae_res_if;
  logic                           valid;
  logic                           ready;
  logic signed [slae_pkg::VAL_W-1:0] read_value;
  logic [1:0]                     status;
  logic [slae_pkg::FILL_W-1:0]    fill_count;

  modport source (output valid, read_value, status, fill_count, input ready);
  modport sink   (input valid, read_value, status, fill_count, output ready);
endinterface
`default_nettype wire

@@ sv/shifting_array_list_engine.sv @@
// Top level: ordered list engine with insert/delete by shifting.
//
//  channel | dir | payload                          | transaction
//  op      | in  | kind, position, value            | op.valid & op.ready
//  res     | out | read_value, status, fill_count   | res.valid & res.ready
//
// The 16-cell register chain shifts the entries from the position on in the same
// clock edge. The result is registered and appears in the cycle after the op
// transaction, and a new op is taken each cycle while res is drained.
// rst is synchronous; it empties the list and drops res.valid. Cell contents
// are not reset. A stalled res holds its payload and blocks further ops.
`default_nettype none
module shifting_array_list_engine (
  input  wire logic clk,
  input  wire logic rst,
  slae_op_if.sink   op,
  slae_res_if.source res
);
  import slae_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  slae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op.valid),
    .op_kind   (op.kind),
    .op_ready  (op.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slae_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .position   (op.position),
    .value      (op.value),
    .cmd        (cmd),
    .sts        (sts),
    .read_value (res.read_value),
    .status     (res.status),
    .fill_count (res.fill_count)
  );

endmodule
`default_nettype wire

@@ sv/slae_ctrl.sv @@
// Controller: result register occupancy and operation decode.
`default_nettype none
module slae_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              op_valid,
  input  wire logic [1:0]        op_kind,
  output logic                   op_ready,
  output logic                   res_valid,
  input  wire logic              res_ready,
  input  wire slae_pkg::dp_sts_t sts,
  output slae_pkg::dp_cmd_t      cmd
);
  import slae_pkg::*;

  res_state_t state, state_next;
  kind_t      kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RES_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    kind       = kind_t'(op_kind);
    res_valid  = (state == RES_HELD);
    op_ready   = (state == RES_EMPTY) || res_ready;
    cmd        = '0;
    cmd.take   = op_valid && op_ready;
    cmd.status = ST_OK;
    unique case (kind)
      KIND_READ: begin
        cmd.rd = sts.pos_lt_cnt;
        if (!sts.pos_lt_cnt) cmd.status = ST_RANGE;
      end
      KIND_UPDATE: begin
        cmd.upd = cmd.take && sts.pos_lt_cnt;
        if (!sts.pos_lt_cnt) cmd.status = ST_RANGE;
      end
      KIND_INSERT: begin
        priority if (sts.full) begin
          cmd.status = ST_FULL;
        end else if (!sts.pos_le_cnt) begin
          cmd.status = ST_RANGE;
        end else begin
          cmd.ins = cmd.take;
        end
      end
      KIND_DELETE: begin
        cmd.del = cmd.take && sts.pos_lt_cnt;
        if (!sts.pos_lt_cnt) cmd.status = ST_RANGE;
      end
      default: cmd.status = ST_OK;
    endcase

    unique case (state)
      RES_EMPTY: state_next = cmd.take ? RES_HELD : RES_EMPTY;
      RES_HELD:  state_next = (cmd.take || !res_ready) ? RES_HELD : RES_EMPTY;
      default:   state_next = RES_EMPTY;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/slae_dp.sv @@
// Datapath: shifting cell chain, fill count and result register.
`default_nettype none
module slae_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [slae_pkg::POS_W-1:0]       position,
  input  wire logic signed [slae_pkg::VAL_W-1:0] value,
  input  wire slae_pkg::dp_cmd_t                cmd,
  output slae_pkg::dp_sts_t                     sts,
  output logic signed [slae_pkg::VAL_W-1:0]     read_value,
  output logic [1:0]                            status,
  output logic [slae_pkg::FILL_W-1:0]           fill_count
);
  import slae_pkg::*;

  logic signed [VAL_W-1:0] cells [CAPACITY];
  logic [FILL_W-1:0]       count, count_next;
  logic signed [VAL_W-1:0] rd_q;
  status_t                 status_q;
  logic [FILL_W-1:0]       fill_q;
  logic signed [VAL_W-1:0] rd_sel;

  assign sts.pos_lt_cnt = (position < count);
  assign sts.pos_le_cnt = (position <= count);
  assign sts.full       = (count >= FILL_W'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] below, above;
    logic                    at_pos, past_pos;

    if (i > 0) begin : g_below
      assign below = cells[i-1];
    end else begin : g_nobelow
      assign below = cells[i];
    end
    if (i < CAPACITY - 1) begin : g_above
      assign above = cells[i+1];
    end else begin : g_noabove
      assign above = cells[i];
    end

    assign at_pos   = (position == POS_W'(i));
    assign past_pos = (POS_W'(i) > position);

    always_ff @(posedge clk) begin
      priority if ((cmd.upd || cmd.ins) && at_pos) begin
        cells[i] <= value;
      end else if (cmd.ins && past_pos) begin
        cells[i] <= below;
      end else if (cmd.del && (past_pos || at_pos)) begin
        cells[i] <= above;
      end
    end
  end

  always_comb begin
    priority if (cmd.ins) begin
      count_next = count + FILL_W'(1);
    end else if (cmd.del) begin
      count_next = count - FILL_W'(1);
    end else begin
      count_next = count;
    end
    rd_sel = cmd.rd ? cells[position[IDX_W-1:0]] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_q     <= rd_sel;
      status_q <= cmd.status;
      fill_q   <= count_next;
    end
  end

  assign read_value = rd_q;
  assign status     = status_q;
  assign fill_count = fill_q;

endmodule
`default_nettype wire

@@ sv/slae_checker.sv @@
// Checker on the top-level ports, bound to the engine.
`default_nettype none
module slae_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        op_valid,
  input wire logic                        op_ready,
  input wire logic                        res_valid,
  input wire logic                        res_ready,
  input wire logic [slae_pkg::VAL_W-1:0]  read_value,
  input wire logic [1:0]                  status,
  input wire logic [slae_pkg::FILL_W-1:0] fill_count
);
  import slae_pkg::*;

  a_op_gives_res: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> res_valid)
    else $error("op transaction not followed by a result");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> fill_count <= FILL_W'(CAPACITY))
    else $error("fill count above capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_OK |-> read_value == '0)
    else $error("failed operation returned data");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_FULL |-> fill_count == FILL_W'(CAPACITY))
    else $error("full status with list not full");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(read_value)
      && $stable(status) && $stable(fill_count))
    else $error("stalled result changed");

endmodule

bind shifting_array_list_engine slae_checker u_slae_checker (
  .clk        (clk),
  .rst        (rst),
  .op_valid   (op.valid),
  .op_ready   (op.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .read_value (res.read_value),
  .status     (res.status),
  .fill_count (res.fill_count)
);
`default_nettype wire
